// File: rtl/itsp_pkg.sv
// Shared types and constants for the IMU tilt and scale publisher.
// No dependencies; used by every module under rtl/.
package itsp_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STAGES    =
    (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS : ATAN_ENTRIES;

  localparam int X_W     = 24;  // CORDIC x/y datapath
  localparam int Z_W     = 26;  // angle accumulator, 2^-16 degree
  localparam int ANGLE_W = 18;  // angle in 1/256 degree before clamping
  localparam int SHIFT_W = 5;
  localparam int ATAN_W  = 22;

  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  localparam logic signed [Z_W-1:0] Z_PLUS_90  = 26'sd5898240;
  localparam logic signed [Z_W-1:0] Z_MINUS_90 = -26'sd5898240;
  localparam logic signed [ANGLE_W-1:0] ANG_180 = 18'sd46080;
  localparam logic signed [ANGLE_W-1:0] ANG_90  = 18'sd23040;

  // Square root of (ax^2 + az^2) * 256
  localparam int RAD_W      = 40;
  localparam int ROOT_W     = 20;
  localparam int SQRT_STEPS = 20;
  localparam int SQRT_CNT_W = 5;

  // floor(n / 131) = (n * GYRO_RECIP) >> 32 for n < 2^24
  localparam logic [24:0] GYRO_RECIP = 25'd32786010;
  localparam logic [23:0] GYRO_HALF  = 24'd65;
  // floor(n / 34000) = (n * TEMP_RECIP) >> 47 for n < 2^31
  localparam logic [31:0] TEMP_RECIP  = 32'd4139337893;
  localparam logic [30:0] TEMP_HALF   = 31'd17000;
  localparam logic signed [31:0] TEMP_SCALE  = 32'sd25600;
  localparam logic signed [31:0] TEMP_OFFSET = 32'sd317957120;

  localparam logic [9:0] PERIOD_BASE_MS    = 10'd1000;
  localparam logic [9:0] PERIOD_DEFAULT_MS = 10'd10;
  localparam logic [9:0] RATE_RESET_HZ     = 10'd100;
  localparam int PDIV_CNT_W = 4;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_RATE   = 1'b1;

  typedef struct packed {
    logic signed [X_W-1:0]     x;
    logic signed [X_W-1:0]     y;
    logic signed [Z_W-1:0]     z;
    logic                      spec;
    logic signed [ANGLE_W-1:0] spec_val;
  } cordic_stage_t;

endpackage

// File: rtl/itsp_cordic_cell.sv
// One vectoring micro-rotation with its output register.
// Depends on itsp_pkg.
module itsp_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid_in,
  input  itsp_pkg::cordic_stage_t       stage_in,
  input  logic [itsp_pkg::SHIFT_W-1:0]  shift,
  input  logic [itsp_pkg::ATAN_W-1:0]   atan_step,
  output logic                          valid_out,
  output itsp_pkg::cordic_stage_t       stage_out
);

  logic signed [itsp_pkg::X_W-1:0] dx;
  logic signed [itsp_pkg::X_W-1:0] dy;
  logic signed [itsp_pkg::Z_W-1:0] dz;
  itsp_pkg::cordic_stage_t         stage_next;

  always_comb begin
    dx = stage_in.y >>> shift;
    dy = stage_in.x >>> shift;
    dz = $signed(itsp_pkg::Z_W'(atan_step));
    stage_next = stage_in;
    if (stage_in.y > 0) begin
      stage_next.x = stage_in.x + dx;
      stage_next.y = stage_in.y - dy;
      stage_next.z = stage_in.z + dz;
    end else if (stage_in.y < 0) begin
      stage_next.x = stage_in.x - dx;
      stage_next.y = stage_in.y + dy;
      stage_next.z = stage_in.z - dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage_out <= stage_next;
  end

endmodule

// File: rtl/itsp_cordic_chain.sv
// atan2 by a row of CORDIC cells: axis cases and pre-rotation, the cells,
// then rounding to 1/256 degree. Depends on itsp_pkg and itsp_cordic_cell.
module itsp_cordic_chain (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [itsp_pkg::X_W-1:0]      x_in,
  input  logic signed [itsp_pkg::X_W-1:0]      y_in,
  output logic                                 done,
  output logic signed [itsp_pkg::ANGLE_W-1:0]  angle
);

  localparam int N = itsp_pkg::CORDIC_STAGES;

  itsp_pkg::cordic_stage_t stage_q [N+1];
  logic                    valid_q [N+1];
  itsp_pkg::cordic_stage_t pre_next;

  logic [itsp_pkg::Z_W-1:0]     z_mag;
  logic [itsp_pkg::Z_W-1:0]     z_rnd;
  logic [itsp_pkg::ANGLE_W-1:0] z_quo;
  logic signed [itsp_pkg::ANGLE_W-1:0] angle_next;

  always_comb begin
    pre_next.x        = x_in;
    pre_next.y        = y_in;
    pre_next.z        = '0;
    pre_next.spec     = 1'b0;
    pre_next.spec_val = '0;
    if (y_in == 0) begin
      pre_next.spec     = 1'b1;
      pre_next.spec_val = (x_in < 0) ? itsp_pkg::ANG_180 : '0;
    end else if (x_in == 0) begin
      pre_next.spec     = 1'b1;
      pre_next.spec_val = (y_in > 0) ? itsp_pkg::ANG_90 : -itsp_pkg::ANG_90;
    end else if (x_in < 0) begin
      // rotate into the right half plane
      if (y_in >= 0) begin
        pre_next.z = itsp_pkg::Z_PLUS_90;
        pre_next.x = y_in;
        pre_next.y = -x_in;
      end else begin
        pre_next.z = itsp_pkg::Z_MINUS_90;
        pre_next.x = -y_in;
        pre_next.y = x_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    stage_q[0] <= pre_next;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    itsp_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_q[i]),
      .stage_in  (stage_q[i]),
      .shift     (itsp_pkg::SHIFT_W'(i)),
      .atan_step (itsp_pkg::ATAN_TAB[i]),
      .valid_out (valid_q[i+1]),
      .stage_out (stage_q[i+1])
    );
  end

  // round to 1/256 degree, halves away from zero
  always_comb begin
    z_mag = stage_q[N].z[itsp_pkg::Z_W-1] ? itsp_pkg::Z_W'(-stage_q[N].z)
                                          : itsp_pkg::Z_W'(stage_q[N].z);
    z_rnd = z_mag + itsp_pkg::Z_W'(128);
    z_quo = itsp_pkg::ANGLE_W'(z_rnd >> 8);
    if (stage_q[N].spec) begin
      angle_next = stage_q[N].spec_val;
    end else if (stage_q[N].z[itsp_pkg::Z_W-1]) begin
      angle_next = -$signed(z_quo);
    end else begin
      angle_next = $signed(z_quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q[N];
    end
  end

  always_ff @(posedge clk) begin
    angle <= angle_next;
  end

endmodule

// File: rtl/itsp_isqrt.sv
// Integer square root, two radicand bits per cycle.
// Depends on itsp_pkg.
module itsp_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [itsp_pkg::RAD_W-1:0]    radicand,
  output logic                          done,
  output logic [itsp_pkg::ROOT_W-1:0]   root
);

  logic [itsp_pkg::RAD_W-1:0]      rem;
  logic [itsp_pkg::RAD_W-1:0]      res;
  logic [itsp_pkg::RAD_W-1:0]      bitv;
  logic [itsp_pkg::SQRT_CNT_W-1:0] cnt;
  logic                            busy;
  logic [itsp_pkg::RAD_W-1:0]      trial;

  assign trial = res + bitv;
  assign root  = res[itsp_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= itsp_pkg::SQRT_CNT_W'(itsp_pkg::SQRT_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= itsp_pkg::RAD_W'(1) << (itsp_pkg::RAD_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// File: rtl/imu_tilt_and_scale_publisher.sv
// Top level: rate gate, scaling of rates and temperature, pitch and roll.
// Depends on itsp_pkg, itsp_isqrt and itsp_cordic_chain.
//
//  port group   dir  handshake              beat
//  sample_*     in   sample_valid/_stall    raw accel, gyro, temp, time_ms
//  result_*     out  result_valid/_stall    stamp, scaled values, angles
//  cfg_*        in   cfg_valid/cfg_ready    register index, data
//
// A sample that is not published is accepted and dropped with sample_stall low.
// A published sample goes through capture, scaling, the square root (two bits a
// cycle), the CORDIC row of 16 cells plus entry and rounding, angle capture and
// result load; sample_stall is high meanwhile and longer if a beat still waits.
// A nonzero rate write runs the divider (1000 / rate) with sample_stall and
// cfg_ready low. Reset is synchronous; enable 0, rate 100 Hz, never published.
module imu_tilt_and_scale_publisher (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] temp_code,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic        [31:0] time_ms,
  output logic               result_valid,
  input  logic               result_stall,
  output logic        [31:0] stamp_ms,
  output logic signed [15:0] acc_x_out,
  output logic signed [15:0] acc_y_out,
  output logic signed [15:0] acc_z_out,
  output logic signed [16:0] rate_x_out,
  output logic signed [16:0] rate_y_out,
  output logic signed [16:0] rate_z_out,
  output logic signed [16:0] temp_out,
  output logic signed [15:0] pitch_out,
  output logic signed [16:0] roll_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [9:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_ANGLE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state;
  logic [1:0]  prep_cnt;
  logic        enable;
  logic [31:0] last_time;
  logic [9:0]  period;

  // period divider
  logic                           div_busy;
  logic [itsp_pkg::PDIV_CNT_W-1:0] div_cnt;
  logic [10:0]                    div_rem;
  logic [9:0]                     div_quo;
  logic [9:0]                     div_den;
  logic [10:0]                    div_shift;

  // captured sample
  logic signed [15:0] ax, ay, az, tc;
  logic signed [15:0] gyro [3];
  logic [31:0]        stamp;

  // scaling datapath
  logic [31:0]        sq_x, sq_z, sq_sum;
  logic signed [31:0] tprod;
  logic [30:0]        tmag;
  logic               tneg;
  logic [15:0]        tq;
  logic [23:0]        gmag [3];
  logic               gneg [3];
  logic [15:0]        gq [3];
  logic signed [16:0] rate_r [3];
  logic signed [16:0] temp_r;
  logic signed [15:0] pitch_r;
  logic signed [16:0] roll_r;

  logic [48:0] gprod [3];
  logic [62:0] tprod_m;

  logic                  sample_acc;
  logic                  publish_ok;
  logic [31:0]           elapsed;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [itsp_pkg::ROOT_W-1:0] root;
  logic                  chain_start;
  logic signed [itsp_pkg::X_W-1:0] pitch_x, pitch_y, roll_x, roll_y;
  logic                  pitch_done, roll_done;
  logic signed [itsp_pkg::ANGLE_W-1:0] pitch_a, roll_a;
  logic signed [15:0]    pitch_c;
  logic signed [16:0]    roll_c;
  logic                  load_out;

  assign sample_stall = (state != ST_IDLE) || div_busy;
  assign cfg_ready    = !div_busy;
  assign sample_acc   = sample_valid && !sample_stall;
  assign elapsed      = time_ms - last_time;
  assign publish_ok   = enable && ((last_time == 0) || (elapsed >= {22'd0, period}));

  // ---------------- configuration and period divider ----------------
  assign div_shift = {div_rem[9:0], div_quo[9]};

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b0;
      period   <= itsp_pkg::PERIOD_DEFAULT_MS;
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == itsp_pkg::CFG_ENABLE) begin
          enable <= cfg_data[0];
        end else if (cfg_data == 0) begin
          period <= itsp_pkg::PERIOD_DEFAULT_MS;
        end else begin
          div_busy <= 1'b1;
          div_cnt  <= itsp_pkg::PDIV_CNT_W'(9);
        end
      end else if (div_busy) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == 0) begin
          div_busy <= 1'b0;
          period   <= (div_shift >= {1'b0, div_den}) ? {div_quo[8:0], 1'b1}
                                                     : {div_quo[8:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready && cfg_index == itsp_pkg::CFG_RATE) begin
      div_den <= cfg_data;
      div_rem <= '0;
      div_quo <= itsp_pkg::PERIOD_BASE_MS;
    end else if (div_busy) begin
      if (div_shift >= {1'b0, div_den}) begin
        div_rem <= div_shift - {1'b0, div_den};
        div_quo <= {div_quo[8:0], 1'b1};
      end else begin
        div_rem <= div_shift;
        div_quo <= {div_quo[8:0], 1'b0};
      end
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prep_cnt  <= '0;
      last_time <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_acc && publish_ok) begin
            state     <= ST_PREP;
            prep_cnt  <= '0;
            last_time <= time_ms;
          end
        end
        ST_PREP: begin
          prep_cnt <= prep_cnt + 1'b1;
          if (prep_cnt == 2'd2) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            state <= ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          if (pitch_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------- scaling datapath ----------------
  for (genvar k = 0; k < 3; k++) begin : g_gyro_mul
    assign gprod[k] = 49'(gmag[k]) * 49'(itsp_pkg::GYRO_RECIP);
  end
  assign tprod_m = 63'(tmag) * 63'(itsp_pkg::TEMP_RECIP);

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      ax      <= accel_x;
      ay      <= accel_y;
      az      <= accel_z;
      tc      <= temp_code;
      gyro[0] <= gyro_x;
      gyro[1] <= gyro_y;
      gyro[2] <= gyro_z;
      stamp   <= time_ms;
    end
    if (state == ST_PREP) begin
      case (prep_cnt)
        2'd0: begin
          sq_x  <= 32'(ax * ax);
          sq_z  <= 32'(az * az);
          tprod <= 32'(32'(tc) * itsp_pkg::TEMP_SCALE) + itsp_pkg::TEMP_OFFSET;
          for (int k = 0; k < 3; k++) begin
            gneg[k] <= gyro[k][15];
            // |gyro| * 256 plus half the divisor
            gmag[k] <= {gyro[k][15] ? 16'(-$signed({gyro[k][15], gyro[k]}))
                                    : 16'(gyro[k]), 8'd0}
                       + itsp_pkg::GYRO_HALF;
          end
        end
        2'd1: begin
          sq_sum <= sq_x + sq_z;
          tneg   <= tprod[31];
          tmag   <= (tprod[31] ? 31'(-tprod) : 31'(tprod)) + itsp_pkg::TEMP_HALF;
          for (int k = 0; k < 3; k++) begin
            gq[k] <= gprod[k][47:32];
          end
        end
        2'd2: begin
          tq <= tprod_m[62:47];
          for (int k = 0; k < 3; k++) begin
            rate_r[k] <= gneg[k] ? -$signed({1'b0, gq[k]}) : $signed({1'b0, gq[k]});
          end
        end
        default: begin
          tq <= tq;
        end
      endcase
    end
    if (state == ST_SQRT) begin
      temp_r <= tneg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
    end
    if (state == ST_ANGLE && pitch_done) begin
      pitch_r <= pitch_c;
      roll_r  <= roll_c;
    end
  end

  // ---------------- angles ----------------
  assign sqrt_start = (state == ST_PREP) && (prep_cnt == 2'd2);

  itsp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({sq_sum, 8'd0}),
    .done     (sqrt_done),
    .root     (root)
  );

  assign chain_start = (state == ST_SQRT) && sqrt_done;
  assign pitch_x = $signed(itsp_pkg::X_W'(root));
  assign pitch_y = itsp_pkg::X_W'(ay) <<< 4;
  assign roll_x  = itsp_pkg::X_W'(az) <<< 4;
  assign roll_y  = -(itsp_pkg::X_W'(ax) <<< 4);

  itsp_cordic_chain u_pitch (
    .clk   (clk),
    .rst   (rst),
    .start (chain_start),
    .x_in  (pitch_x),
    .y_in  (pitch_y),
    .done  (pitch_done),
    .angle (pitch_a)
  );

  itsp_cordic_chain u_roll (
    .clk   (clk),
    .rst   (rst),
    .start (chain_start),
    .x_in  (roll_x),
    .y_in  (roll_y),
    .done  (roll_done),
    .angle (roll_a)
  );

  always_comb begin
    if (pitch_a > itsp_pkg::ANG_90) begin
      pitch_c = 16'(itsp_pkg::ANG_90);
    end else if (pitch_a < -itsp_pkg::ANG_90) begin
      pitch_c = 16'(-itsp_pkg::ANG_90);
    end else begin
      pitch_c = 16'(pitch_a);
    end
    if (roll_a > itsp_pkg::ANG_180) begin
      roll_c = 17'(itsp_pkg::ANG_180);
    end else if (roll_a < -itsp_pkg::ANG_180) begin
      roll_c = 17'(-itsp_pkg::ANG_180);
    end else begin
      roll_c = 17'(roll_a);
    end
  end

  // ---------------- result register ----------------
  assign load_out = (state == ST_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      stamp_ms   <= stamp;
      acc_x_out  <= ax;
      acc_y_out  <= ay;
      acc_z_out  <= az;
      rate_x_out <= rate_r[0];
      rate_y_out <= rate_r[1];
      rate_z_out <= rate_r[2];
      temp_out   <= temp_r;
      pitch_out  <= pitch_r;
      roll_out   <= roll_r;
    end
  end

  // ---------------- assertions ----------------
  a_publish_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_acc && publish_ok) |=> (state == ST_PREP && last_time == $past(time_ms)))
    else $error("published sample did not start processing");

  a_chains_aligned: assert property (@(posedge clk) disable iff (rst)
    pitch_done == roll_done)
    else $error("pitch and roll chains out of step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside completion");

endmodule
